// ----- rtl/voip_r_factor_estimator_macros.svh -----
// Assertion helpers for the R-factor estimator.
`ifndef VOIP_R_FACTOR_ESTIMATOR_MACROS_SVH
`define VOIP_R_FACTOR_ESTIMATOR_MACROS_SVH

// Checked while reset is released.
`define VRE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define VRE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/vre_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package vre_pkg;

    localparam int DELAY_W   = 24;
    localparam int COUNT_W   = 32;
    localparam int CFG_W     = 11;
    localparam int R_W       = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_CODEC  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROBUST = 1'd1;

    localparam logic [CFG_W-1:0] CODEC_RST  = 11'd0;
    localparam logic [CFG_W-1:0] ROBUST_RST = 11'd160;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK          = 2'd0;
    localparam t_status ST_NO_EXPECTED = 2'd1;
    localparam t_status ST_NO_BURSTS   = 2'd2;
    localparam t_status ST_OVERLOSS    = 2'd3;

    localparam logic [DELAY_W-1:0] DELAY_KNEE_US = 24'd177300;
    localparam logic signed [33:0] R_BASE_MICRO  = 34'sd93200000;
    localparam logic [CFG_W-1:0]   IE_MAX        = 11'd1520;

    // Divider geometry: 64-bit dividend, 44-bit divisor, 34 quotient bits.
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 44;
    localparam int DIV_QB    = 34;

    // Delay term: floor(x * 2^14 / 15625) by reciprocal multiplies.
    // x is biased up by 15625 * 2^18 so the quotient step sees a 32-bit unsigned.
    localparam logic signed [33:0] DELAY_OFFSET = 34'sd4096000000;
    localparam logic [13:0]        DELAY_DIV    = 14'd15625;
    localparam logic [32:0]        DELAY_RECIP  = 33'd4503599628;  // ceil(2^46 / 15625)
    localparam logic [28:0]        FRAC_RECIP   = 29'd281474977;   // ceil(2^42 / 15625)

    typedef struct packed {
        t_status status;
        logic    loss_on;
        logic    g_clamp;
    } t_side;

endpackage
`default_nettype wire

// ----- rtl/vre_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface vre_in_if;
    logic                         valid;
    logic                         ready;
    logic [vre_pkg::DELAY_W-1:0]  mean_delay_us;
    logic [vre_pkg::COUNT_W-1:0]  expected_count;
    logic [vre_pkg::COUNT_W-1:0]  loss_sum;
    logic [vre_pkg::COUNT_W-1:0]  loss_bursts;

    modport source (output valid, mean_delay_us, expected_count, loss_sum, loss_bursts,
                    input ready);
    modport sink (input valid, mean_delay_us, expected_count, loss_sum, loss_bursts,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/vre_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface vre_out_if;
    logic                           valid;
    logic                           ready;
    logic signed [vre_pkg::R_W-1:0] r_value;
    vre_pkg::t_status               status;
    logic                           saturated;

    modport source (output valid, r_value, status, saturated, input ready);
    modport sink (input valid, r_value, status, saturated, output ready);
endinterface
`default_nettype wire

// ----- rtl/vre_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage.
// Requires i_num >> DIV_QB < i_den so the quotient fits in DIV_QB bits.
module vre_div (
    input  wire logic                            i_clk,
    input  wire logic                            i_en,
    input  wire logic [vre_pkg::DIV_NUM_W-1:0]   i_num,
    input  wire logic [vre_pkg::DIV_DEN_W-1:0]   i_den,
    output logic      [vre_pkg::DIV_QB-1:0]      o_quot
);
    localparam int NW = vre_pkg::DIV_NUM_W;
    localparam int DW = vre_pkg::DIV_DEN_W;
    localparam int QB = vre_pkg::DIV_QB;

    logic [DW-1:0] r_rem [0:QB];
    logic [QB-1:0] r_low [0:QB];
    logic [DW-1:0] r_den [0:QB];
    logic [DW-1:0] n_rem [1:QB];
    logic [QB-1:0] n_low [1:QB];

    always_comb begin
        logic [DW:0] t;
        logic        ge;
        for (int i = 0; i < QB; i++) begin
            t  = {r_rem[i], r_low[i][QB-1]};
            ge = (t >= {1'b0, r_den[i]});
            n_rem[i+1] = ge ? DW'(t - {1'b0, r_den[i]}) : t[DW-1:0];
            n_low[i+1] = {r_low[i][QB-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= DW'(i_num[NW-1:QB]);
            r_low[0] <= i_num[QB-1:0];
            r_den[0] <= i_den;
            for (int i = 1; i <= QB; i++) begin
                r_rem[i] <= n_rem[i];
                r_low[i] <= n_low[i];
                r_den[i] <= r_den[i-1];
            end
        end
    end

    assign o_quot = r_low[QB];
endmodule
`default_nettype wire

// ----- rtl/voip_r_factor_estimator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Voice-quality estimator: simplified E-model R-factor, one report per word.
// Input channel i_in: mean delay (us), expected, lost and burst counts of one
// report interval. Output channel o_out: R in 1/256 units (saturated), status
// code and a saturation flag, one word per input word, in order.
// Config port: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 codec impairment Ie, 1 loss robustness Bpl, both in 1/16 units).
// Write config only while no word is in flight.
// Throughput: one word per cycle while no stall holds the pipeline; the two
// dividers (loss ratio, burst factor) are 34-stage pipelines and set the
// latency; the delay term is scaled by reciprocal multiplies over ranks kept
// in step with them.
// Stall: when o_out holds a word that is not taken, the whole pipeline
// freezes and i_in.ready drops in the same cycle; nothing is lost. A word in
// the output register is released and a new one taken in the same cycle.
// Reset (synchronous, active low) empties the pipeline and loads Ie = 0,
// Bpl = 160/16.
module voip_r_factor_estimator (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [vre_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [vre_pkg::CFG_W-1:0]         i_cfg_data,
    vre_in_if.sink                                 i_in,
    vre_out_if.source                              o_out
);
    localparam int QB = vre_pkg::DIV_QB;

    logic [vre_pkg::CFG_W-1:0] r_ci, r_bpl;

    // global advance: the pipeline moves when the output slot frees up
    logic adv;
    logic r_out_valid;
    assign adv        = !r_out_valid || o_out.ready;
    assign i_in.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ci  <= vre_pkg::CODEC_RST;
            r_bpl <= vre_pkg::ROBUST_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vre_pkg::REG_CODEC:  r_ci  <= i_cfg_data;
                vre_pkg::REG_ROBUST: r_bpl <= i_cfg_data;
            endcase
        end
    end

    // ---- stage A: status, loss gating, delay impairment in 1e-6 units ----
    vre_pkg::t_status n_a_status;
    logic             n_a_loss_on;
    logic [31:0]      n_a_idn;
    logic [23:0]      a_over;

    always_comb begin
        priority if (i_in.expected_count == '0) begin
            n_a_status = vre_pkg::ST_NO_EXPECTED;
        end else if (i_in.loss_sum > i_in.expected_count) begin
            n_a_status = vre_pkg::ST_OVERLOSS;
        end else if (i_in.loss_sum != '0 && i_in.loss_bursts == '0) begin
            n_a_status = vre_pkg::ST_NO_BURSTS;
        end else begin
            n_a_status = vre_pkg::ST_OK;
        end
        n_a_loss_on = (i_in.expected_count != '0) && (i_in.loss_sum != '0)
                      && (i_in.loss_sum < i_in.expected_count);
        a_over  = (i_in.mean_delay_us >= vre_pkg::DELAY_KNEE_US)
                  ? i_in.mean_delay_us - vre_pkg::DELAY_KNEE_US : '0;
        n_a_idn = 32'(i_in.mean_delay_us) * 32'd24 + 32'(a_over) * 32'd110;
    end

    logic             r_a_valid;
    vre_pkg::t_status r_a_status;
    logic             r_a_loss_on;
    logic [31:0]      r_a_idn, r_a_rem, r_a_e, r_a_l, r_a_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= i_in.valid;
        end
        if (adv) begin
            r_a_status  <= n_a_status;
            r_a_loss_on <= n_a_loss_on;
            r_a_idn     <= n_a_idn;
            r_a_rem     <= i_in.expected_count - i_in.loss_sum;
            r_a_e       <= i_in.expected_count;
            r_a_l       <= i_in.loss_sum;
            r_a_b       <= i_in.loss_bursts;
        end
    end

    // ---- stage B: burst products, biased delay numerator ----
    logic signed [33:0] b_x;
    logic [31:0]        b_u;
    assign b_x = vre_pkg::R_BASE_MICRO - $signed({2'b00, r_a_idn});
    assign b_u = 32'(b_x + vre_pkg::DELAY_OFFSET);

    logic             r_b_valid;
    vre_pkg::t_status r_b_status;
    logic             r_b_loss_on;
    logic [42:0]      r_b_p1, r_b_p2;
    logic [31:0]      r_b_u;
    logic [31:0]      r_b_rem, r_b_e, r_b_l;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (adv) begin
            r_b_valid <= r_a_valid;
        end
        if (adv) begin
            r_b_status  <= r_a_status;
            r_b_loss_on <= r_a_loss_on;
            r_b_p1      <= 43'(r_a_b) * 43'd1600;
            r_b_p2      <= 43'(r_a_rem) * 43'(r_bpl);
            r_b_u       <= b_u;
            r_b_rem     <= r_a_rem;
            r_b_e       <= r_a_e;
            r_b_l       <= r_a_l;
        end
    end

    // ---- stage C: burst denominator and clamp test, into the dividers ----
    logic [43:0]    c_den;
    vre_pkg::t_side c_side;
    assign c_den          = {1'b0, r_b_p1} + {1'b0, r_b_p2};
    assign c_side.status  = r_b_status;
    assign c_side.loss_on = r_b_loss_on;
    // G saturates when rem * 2^20 / den would reach 2^32 (also for den zero)
    assign c_side.g_clamp = {24'b0, r_b_rem} >= {c_den, 12'b0};

    logic [QB-1:0] q_p, q_g;

    vre_div u_div_ppl (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_num  ({r_b_l, 32'b0}),
        .i_den  ({12'b0, r_b_e}),
        .o_quot (q_p)
    );

    vre_div u_div_g (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_num  ({12'b0, r_b_rem, 20'b0}),
        .i_den  (c_den),
        .o_quot (q_g)
    );

    // delay scaling, ranks in step with the dividers:
    // u = q * 15625 + rem, d20 = (q - 2^18) * 2^14 + floor(rem * 2^14 / 15625)
    logic [31:0]        r_dl_u0, r_dl_u1;
    logic [18:0]        r_dl_q1, r_dl_q2, r_dl_q3;
    logic [13:0]        r_dl_rm2, r_dl_fr3;
    logic signed [34:0] r_dl_d20 [4:QB];
    logic [64:0]        dl_p1;
    logic [31:0]        dl_qd;
    logic [42:0]        dl_p3;

    assign dl_p1 = 65'(r_dl_u0) * 65'(vre_pkg::DELAY_RECIP);
    assign dl_qd = 32'(r_dl_q1) * 32'(vre_pkg::DELAY_DIV);
    assign dl_p3 = 43'(r_dl_rm2) * 43'(vre_pkg::FRAC_RECIP);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dl_u0     <= r_b_u;
            r_dl_u1     <= r_dl_u0;
            r_dl_q1     <= dl_p1[64:46];
            r_dl_q2     <= r_dl_q1;
            r_dl_rm2    <= 14'(r_dl_u1 - dl_qd);
            r_dl_q3     <= r_dl_q2;
            r_dl_fr3    <= dl_p3[41:28];
            r_dl_d20[4] <= $signed({2'b00, r_dl_q3, r_dl_fr3}) - 35'sd4294967296;
            for (int i = 5; i <= QB; i++) r_dl_d20[i] <= r_dl_d20[i-1];
        end
    end

    // side line matched to the divider ranks
    logic           r_s_valid [0:QB];
    vre_pkg::t_side r_side    [0:QB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= QB; i++) r_s_valid[i] <= 1'b0;
        end else if (adv) begin
            r_s_valid[0] <= r_b_valid;
            for (int i = 1; i <= QB; i++) r_s_valid[i] <= r_s_valid[i-1];
        end
        if (adv) begin
            r_side[0] <= c_side;
            for (int i = 1; i <= QB; i++) r_side[i] <= r_side[i-1];
        end
    end

    // ---- stage D: delay term, loss ratio times burst factor ----
    logic [31:0] d_g;
    assign d_g = r_side[QB].g_clamp ? 32'hFFFF_FFFF : q_g[31:0];

    logic               r_d_valid;
    vre_pkg::t_side     r_d_side;
    logic signed [34:0] r_d_d20;
    logic [63:0]        r_d_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (adv) begin
            r_d_valid <= r_s_valid[QB];
        end
        if (adv) begin
            r_d_side <= r_side[QB];
            r_d_d20  <= r_dl_d20[QB];
            r_d_prod <= 64'(q_p[31:0]) * 64'(d_g);
        end
    end

    // ---- stage E: loss factor F (Q16) and delay minus Ie ----
    logic               r_e_valid;
    vre_pkg::t_status   r_e_status;
    logic [38:0]        r_e_f;
    logic signed [35:0] r_e_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (adv) begin
            r_e_valid <= r_d_valid;
        end
        if (adv) begin
            r_e_status <= r_d_side.status;
            r_e_f      <= r_d_side.loss_on ? 39'(r_d_prod[63:32]) * 39'd100 : '0;
            r_e_base   <= 36'(r_d_d20) - $signed({9'b0, r_ci, 16'b0});
        end
    end

    // ---- stage F: (95 - Ie) * F ----
    logic signed [11:0] f_k16;
    assign f_k16 = $signed({1'b0, vre_pkg::IE_MAX}) - $signed({1'b0, r_ci});

    logic               r_f_valid;
    vre_pkg::t_status   r_f_status;
    logic signed [35:0] r_f_base;
    logic signed [51:0] r_f_term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (adv) begin
            r_f_valid <= r_e_valid;
        end
        if (adv) begin
            r_f_status <= r_e_status;
            r_f_base   <= r_e_base;
            r_f_term   <= 52'(f_k16) * $signed({13'b0, r_e_f});
        end
    end

    // ---- output stage: Q20 sum, round half up to 1/256, saturate ----
    logic signed [53:0] g_r20;
    logic signed [41:0] g_rs;
    logic signed [15:0] g_r;
    logic               g_sat;

    always_comb begin
        g_r20 = 54'(r_f_base) - 54'(r_f_term);
        g_rs  = 42'((g_r20 + 54'sd2048) >>> 12);
        if (g_rs > 42'sd32767) begin
            g_r   = 16'sh7FFF;
            g_sat = 1'b1;
        end else if (g_rs < -42'sd32768) begin
            g_r   = -16'sh8000;
            g_sat = 1'b1;
        end else begin
            g_r   = g_rs[15:0];
            g_sat = 1'b0;
        end
    end

    logic signed [15:0] r_out_r;
    vre_pkg::t_status   r_out_status;
    logic               r_out_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_f_valid;
        end
        if (adv) begin
            r_out_r      <= g_r;
            r_out_status <= r_f_status;
            r_out_sat    <= g_sat;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.r_value   = r_out_r;
    assign o_out.status    = r_out_status;
    assign o_out.saturated = r_out_sat;
endmodule
`default_nettype wire

// ----- rtl/vre_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "voip_r_factor_estimator_macros.svh"
module vre_checker (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_in_ready,
    input wire logic                   i_out_valid,
    input wire logic                   i_out_ready,
    input wire logic [vre_pkg::R_W-1:0] i_r_value,
    input wire logic [1:0]             i_status,
    input wire logic                   i_saturated
);
    `VRE_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !i_out_valid, "output valid after reset")
    `VRE_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid |-> i_in_ready, "input stalled with empty output")
    `VRE_ASSERT(a_sat_extreme, i_clk, i_rst_n, (i_out_valid && i_saturated) |-> (i_r_value == 16'h7FFF || i_r_value == 16'h8000), "saturated word not at a rail")
    `VRE_ASSERT(a_hold_on_stall, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_r_value) && $stable(i_status) && $stable(i_saturated)), "stalled word changed")
endmodule

bind voip_r_factor_estimator vre_checker u_vre_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_r_value   (o_out.r_value),
    .i_status    (o_out.status),
    .i_saturated (o_out.saturated)
);
`default_nettype wire

// ----- test/r_factor_checker.sv -----
`timescale 1ns / 1ps
module r_factor_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [vre_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [vre_pkg::CFG_W-1:0]   i_cfg_data,
    vre_in_if                           i_in,
    vre_out_if                          i_out,
    output int                          o_errors,
    output int                          o_pending,
    output int                          o_seen
);
    import vre_pkg::*;

    typedef struct {
        logic signed [15:0] r;
        t_status            st;
        logic               sat;
    } t_rating;

    t_rating          rating_q[$];
    logic [CFG_W-1:0] ie_reg;
    logic [CFG_W-1:0] bpl_reg;

    function automatic longint fdiv(longint a, longint d);
        if (a >= 0) return a / d;
        return -((-a + d - 1) / d);
    endfunction

    function automatic t_rating rate_report(logic [23:0] dus, logic [31:0] e,
                                            logic [31:0] l, logic [31:0] b);
        t_rating     res;
        logic [63:0] idn, fq, rem, ppl, den, g;
        logic [127:0] prod;
        longint      d20, r20, r256, k16;
        res.st = ST_OK;
        if (e == 0) res.st = ST_NO_EXPECTED;
        else if (l > e) res.st = ST_OVERLOSS;
        else if (l != 0 && b == 0) res.st = ST_NO_BURSTS;
        idn = 24 * 64'(dus);
        if (dus >= DELAY_KNEE_US) idn += 110 * (64'(dus) - 64'(DELAY_KNEE_US));
        d20 = fdiv((longint'(93200000) - longint'(idn)) * 1048576, 1000000);
        fq = 0;
        if (e != 0 && l != 0 && l < e) begin
            rem = 64'(e) - 64'(l);
            ppl = (64'(l) << 32) / 64'(e);
            den = 1600 * 64'(b) + 64'(bpl_reg) * rem;
            if (den == 0) g = 64'hFFFF_FFFF;
            else begin
                g = (rem << 20) / den;
                if (g > 64'hFFFF_FFFF) g = 64'hFFFF_FFFF;
            end
            prod = 128'(ppl) * 128'(g);
            fq = 64'(prod >> 32) * 100;
        end
        k16 = 1520 - longint'(ie_reg);
        r20 = d20 - longint'(ie_reg) * 65536 - k16 * longint'(fq);
        r256 = fdiv(r20 + 2048, 4096);
        res.sat = 0;
        if (r256 > 32767) begin
            r256 = 32767; res.sat = 1;
        end else if (r256 < -32768) begin
            r256 = -32768; res.sat = 1;
        end
        res.r = 16'(r256);
        return res;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %0s: got %0d want %0d at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_seen = 0;
    end
    assign o_pending = rating_q.size();

    always @(posedge i_clk) begin
        t_rating w;
        if (!i_rst_n) begin
            ie_reg  <= CODEC_RST;
            bpl_reg <= ROBUST_RST;
            rating_q.delete();
        end else begin
            // output side first: a word entering now cannot leave this edge
            if (i_out.valid && i_out.ready) begin
                o_seen++;
                if (rating_q.size() == 0) report("unexpected word", i_out.r_value, 0);
                else begin
                    w = rating_q[0];
                    rating_q.delete(0);
                    if (i_out.r_value !== w.r) report("r_value", i_out.r_value, w.r);
                    if (i_out.status !== w.st) report("status", i_out.status, w.st);
                    if (i_out.saturated !== w.sat) report("saturated", i_out.saturated, w.sat);
                end
            end
            if (i_in.valid && i_in.ready)
                rating_q.insert(rating_q.size(),
                                rate_report(i_in.mean_delay_us, i_in.expected_count,
                                            i_in.loss_sum, i_in.loss_bursts));
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_CODEC) ie_reg <= i_cfg_data;
                else if (i_cfg_idx == REG_ROBUST) bpl_reg <= i_cfg_data;
            end
        end
    end
endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
    import vre_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    int                   errors, pending, seen;
    int                   send_idle, recv_stall; // percent
    int                   sent;

    vre_in_if  in_ch();
    vre_out_if out_ch();

    voip_r_factor_estimator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    r_factor_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in(in_ch), .i_out(out_ch),
        .o_errors(errors), .o_pending(pending), .o_seen(seen)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // watchdog: 1250 items under 85% stalls stay far below this
    initial begin
        #20ms;
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end

    // receiver: stall at random per the current phase
    always @(negedge i_clk)
        out_ch.ready <= ($urandom_range(99) >= recv_stall);

    // push one word; idle at random first, then hold until taken
    task automatic send_word(logic [23:0] d, logic [31:0] e, logic [31:0] l,
                             logic [31:0] b);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 0;
            @(negedge i_clk);
        end
        in_ch.valid          <= 1;
        in_ch.mean_delay_us  <= d;
        in_ch.expected_count <= e;
        in_ch.loss_sum       <= l;
        in_ch.loss_bursts    <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    // drain: nothing pending, then idle past the pipeline depth
    task automatic drain();
        in_ch.valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        @(negedge i_clk);
    endtask

    // random report: four kinds in ten are plausible, losses below expected with bursts
    task automatic send_random();
        logic [23:0] d;
        logic [31:0] e, l, b;
        int kind;
        kind = $urandom_range(9);
        d = (kind < 6) ? 24'($urandom_range(400000)) : 24'($urandom);
        e = (kind < 5) ? 32'($urandom_range(5000, 1)) : $urandom;
        case (kind)
            0, 1, 2, 3: l = (e > 1) ? 32'($urandom_range(e - 1)) : 0;
            4:          l = e;
            5:          l = e + 32'($urandom_range(10));
            default:    l = $urandom;
        endcase
        b = (kind < 4) ? 32'($urandom_range(l)) : $urandom;
        if ($urandom_range(7) == 0) b = 0;
        if ($urandom_range(15) == 0) e = 0;
        send_word(d, e, l, b);
    endtask

    initial begin
        int ie_set[5];
        int bpl_set[5];
        ie_set  = '{0, 1520, 2047, 400, 1000};
        bpl_set = '{160, 16, 1600, 0, 2047};
        i_rst_n = 0; i_cfg_we = 0; i_cfg_idx = 0; i_cfg_data = 0;
        in_ch.valid = 0; in_ch.mean_delay_us = 0; in_ch.expected_count = 0;
        in_ch.loss_sum = 0; in_ch.loss_bursts = 0; out_ch.ready = 0;
        send_idle = 0; recv_stall = 0; sent = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // directed: reset config, then field extremes and each status case
        send_word(0, 100, 0, 0);                         // no losses
        send_word(24'hFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFE, 32'hFFFFFFFF);
        send_word(177299, 1000, 10, 2);                  // just below knee
        send_word(177300, 1000, 10, 2);                  // on the knee
        send_word(50000, 1000, 1000, 5);                 // everything lost
        send_word(50000, 0, 5, 1);                       // expected zero
        send_word(50000, 10, 20, 1);                     // losses exceed expected
        send_word(50000, 1000, 30, 0);                   // losses, no bursts
        send_word(0, 32'hFFFFFFFF, 1, 32'hFFFFFFFF);
        send_word(0, 2, 1, 1);
        send_word(24'hFFFFFF, 0, 0, 0);
        drain();
        write_reg(REG_ROBUST, 0);                        // zero divisor in G
        write_reg(REG_CODEC, 2047);                      // Ie above 95
        send_word(10000, 1000, 400, 0);
        send_word(10000, 1000, 400, 3);
        send_word(0, 32'hFFFFFFFF, 32'h7FFFFFFF, 0);
        drain();

        // random phases over several config points
        for (int ph = 0; ph < 10; ph++) begin
            write_reg(REG_CODEC, ie_set[ph % 5]);
            write_reg(REG_ROBUST, bpl_set[(ph + 2) % 5]);
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 85; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 85; end
                default: begin send_idle = 30; recv_stall = 30; end
            endcase
            for (int n = 0; n < 125; n++) begin
                send_random();
                // sender holds off until all results are back, once
                if (ph == 3 && n == 60) begin
                    in_ch.valid <= 0;
                    while (pending != 0) @(negedge i_clk);
                end
            end
            drain();
        end

        $display("covered %0d reports, %0d results, 12 config settings, 4 idle patterns",
                 sent, seen);
        if (errors == 0 && pending == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end
endmodule
